// ===== design/socrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// socrb_pkg
// Types and constants shared by the system register block: request and
// response payloads, action codes, group windows and store indices.
// ----------------------------------------------------------------------------
package socrb_pkg;

  // store geometry
  localparam int unsigned STORE_WORDS = 96;
  localparam int unsigned IDX_W       = $clog2(STORE_WORDS);

  typedef logic [IDX_W-1:0] idx_t;

  // action codes carried in a request
  typedef enum logic [2:0] {
    ACT_READ  = 3'd0,
    ACT_WRITE = 3'd1,
    ACT_FIQ   = 3'd2,
    ACT_EXT3  = 3'd3,
    ACT_RESET = 3'd4
  } action_t;

  // request payload
  typedef struct packed {
    logic [2:0]  action;
    logic [28:0] word_offset;
    logic [31:0] write_data;
    logic        line_level;
  } req_t;

  // response payload
  typedef struct packed {
    logic [31:0] read_data;
    logic        fiq_out;
    logic        irq_out;
    logic        boot_rom_mapped;
    logic        unhandled_access;
  } rsp_t;

  // decode result
  typedef struct packed {
    logic hit;
    idx_t idx;
  } dec_t;

  // group base indices in the store
  localparam idx_t GRP_INT    = 7'd0;
  localparam idx_t GRP_EXTMEM = 7'd16;
  localparam idx_t GRP_CACHE  = 7'd20;
  localparam idx_t GRP_DRAM   = 7'd28;
  localparam idx_t GRP_EXPINT = 7'd36;
  localparam idx_t GRP_CHIP   = 7'd44;
  localparam idx_t GRP_PORT   = 7'd48;
  localparam idx_t GRP_SYS    = 7'd80;
  localparam idx_t GRP_TIMER  = 7'd88;

  // 16-byte block numbers relative to the 0x78000000 base
  localparam logic [26:0] BLK_INT_LAST  = 27'h0000002;
  localparam logic [26:0] BLK_EXTMEM    = 27'h0010000;
  localparam logic [26:0] BLK_CACHE     = 27'h0020000;
  localparam logic [26:0] BLK_DRAM      = 27'h0018000;
  localparam logic [26:0] BLK_EXPINT    = 27'h03F0000;
  localparam logic [26:0] BLK_CHIP      = 27'h3F00000;
  localparam logic [26:0] BLK_PORT_LO   = 27'h3FA0100;
  localparam logic [26:0] BLK_PORT_HI   = 27'h3FA0105;
  localparam logic [26:0] BLK_SYS       = 27'h4000000;
  localparam logic [26:0] BLK_TIMER     = 27'h4000100;

  // words with side effects
  localparam logic [28:0] WOFF_INT_NUM   = 29'd5;   // 0x78000014
  localparam logic [28:0] WOFF_LEVEL_CLR = 29'd10;  // 0x78000028

  // store entries with special roles
  localparam idx_t IDX_INT_FIQ   = GRP_INT + 7'd4;
  localparam idx_t IDX_INT_NUM   = GRP_INT + 7'd5;
  localparam idx_t IDX_INT_LEVEL = GRP_INT + 7'd6;
  localparam idx_t IDX_EXPINT_HI = GRP_EXPINT + 7'd6;
  localparam idx_t IDX_CHIP_BOOT = GRP_CHIP + 7'd3;
  localparam idx_t IDX_SYS_REMAP = GRP_SYS + 7'd4;

  localparam logic [31:0] EXT3_INT_NUM = 32'd31;

  // word offset to store index
  function automatic dec_t decode(input logic [28:0] woff);
    logic [26:0] blk;
    dec_t        d;
    blk   = woff[28:2];
    d.hit = 1'b1;
    d.idx = '0;
    if (blk <= BLK_INT_LAST) begin
      d.idx = GRP_INT + {3'd0, woff[3:0]};
    end else if (blk == BLK_EXTMEM) begin
      d.idx = GRP_EXTMEM + {5'd0, woff[1:0]};
    end else if (blk == BLK_CACHE || blk == BLK_CACHE + 27'd1) begin
      d.idx = GRP_CACHE + {4'd0, woff[2:0]};
    end else if (blk == BLK_DRAM || blk == BLK_DRAM + 27'd1) begin
      d.idx = GRP_DRAM + {4'd0, woff[2:0]};
    end else if (blk == BLK_EXPINT || blk == BLK_EXPINT + 27'd1) begin
      d.idx = GRP_EXPINT + {4'd0, woff[2:0]};
    end else if (blk == BLK_CHIP) begin
      d.idx = GRP_CHIP + {5'd0, woff[1:0]};
    end else if (blk >= BLK_PORT_LO && blk <= BLK_PORT_HI) begin
      d.idx = GRP_PORT + {2'd0, woff[4:0]};
    end else if (blk == BLK_SYS || blk == BLK_SYS + 27'd1) begin
      d.idx = GRP_SYS + {4'd0, woff[2:0]};
    end else if (blk == BLK_TIMER || blk == BLK_TIMER + 27'd1) begin
      d.idx = GRP_TIMER + {4'd0, woff[2:0]};
    end else begin
      d.hit = 1'b0;
    end
    return d;
  endfunction

endpackage

// ===== design/soc_system_register_block.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soc_system_register_block
// Register block of a system-on-chip: decoded word store, interrupt side
// effects and derived interrupt and boot mapping outputs.
// ----------------------------------------------------------------------------
// Usage
// - req channel (req_valid / req_stall / req) carries reads, writes, line
//   events and reset actions; rsp channel returns exactly one response per
//   request, in order.
// - The 96-word store is a synchronous memory with one read and one write
//   port. A request is decoded and its memory read and any write happen at the
//   accept edge; the response is then loaded into the output register once
//   that register is empty or being taken, and rsp_valid rises with it.
// - Throughput is one request per cycle while rsp_stall is low: each memory
//   port is used at most once per request and the next request is accepted
//   while the previous one moves into the output register.
// - When rsp_stall holds a response, one further request can be accepted;
//   after that req_stall stays high until the response is taken.
// - rst clears the per-entry valid bits and line levels and resets the
//   derived bits; entries that are not valid read as their reset value.
//   The reset action does the same, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module soc_system_register_block
  import socrb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // word store and per-entry valid bits
  logic [31:0]            store_mem [STORE_WORDS];
  logic [STORE_WORDS-1:0] store_vld;

  // line levels and shadow copies of the bits behind the derived outputs
  logic fast_level;
  logic ext3_level;
  logic fiq_en;
  logic irq_src;
  logic boot_sel;
  logic remap;

  // request in flight between memory read and output register
  logic        pend;
  logic [31:0] rd_q;
  logic        rd_en;
  logic        rd_vld;
  logic        rd_boot;
  logic        rd_unh;

  logic        accept;
  logic        load;
  dec_t        dec;
  logic        is_read;
  logic        is_write;
  logic        mem_we;
  idx_t        mem_wa;
  logic [31:0] mem_wd;

  // handshake
  assign accept    = req_valid && !req_stall;
  assign load      = pend && (!rsp_valid || !rsp_stall);
  assign req_stall = pend && rsp_valid && rsp_stall;

  // decode
  assign dec      = decode(req.word_offset);
  assign is_read  = (req.action == ACT_READ);
  assign is_write = (req.action == ACT_WRITE);

  // memory write port
  always_comb begin
    mem_we = 1'b0;
    mem_wa = dec.idx;
    mem_wd = req.write_data;
    case (req.action)
      ACT_WRITE: begin
        mem_we = dec.hit;
      end
      ACT_EXT3: begin
        mem_we = req.line_level;
        mem_wa = IDX_INT_NUM;
        mem_wd = EXT3_INT_NUM;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // store memory: read before write, one read and at most one write
  always_ff @(posedge clk) begin
    if (accept) begin
      if (mem_we) begin
        store_mem[mem_wa] <= mem_wd;
      end
      rd_q <= store_mem[dec.idx];
    end
  end

  // read side flags travelling with the memory data
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_en   <= is_read && dec.hit;
      rd_vld  <= store_vld[dec.idx];
      rd_boot <= (dec.idx == IDX_CHIP_BOOT);
      rd_unh  <= (is_read || is_write) && !dec.hit;
    end
  end

  // valid bits, line levels and derived bits
  always_ff @(posedge clk) begin
    if (rst) begin
      store_vld  <= '0;
      fast_level <= 1'b0;
      ext3_level <= 1'b0;
      fiq_en     <= 1'b0;
      irq_src    <= 1'b0;
      boot_sel   <= 1'b1;
      remap      <= 1'b0;
    end else if (accept) begin
      case (req.action)
        ACT_READ: begin
          // reading the interrupt number clears it and the current level
          if (dec.hit && req.word_offset == WOFF_INT_NUM) begin
            store_vld[IDX_INT_NUM]   <= 1'b0;
            store_vld[IDX_INT_LEVEL] <= 1'b0;
          end
        end
        ACT_WRITE: begin
          if (dec.hit) begin
            store_vld[dec.idx] <= 1'b1;
            if (req.word_offset == WOFF_LEVEL_CLR) begin
              store_vld[IDX_INT_LEVEL] <= 1'b0;
            end
            if (dec.idx == IDX_INT_FIQ) begin
              fiq_en <= req.write_data[0];
            end
            if (dec.idx == IDX_EXPINT_HI) begin
              irq_src <= |req.write_data[31:28];
            end
            if (dec.idx == IDX_CHIP_BOOT) begin
              boot_sel <= req.write_data[0];
            end
            if (dec.idx == IDX_SYS_REMAP) begin
              remap <= req.write_data[3];
            end
          end
        end
        ACT_FIQ: begin
          fast_level <= req.line_level;
        end
        ACT_EXT3: begin
          ext3_level <= req.line_level;
          if (req.line_level) begin
            store_vld[IDX_INT_NUM] <= 1'b1;
          end
        end
        ACT_RESET: begin
          store_vld  <= '0;
          fast_level <= 1'b0;
          ext3_level <= 1'b0;
          fiq_en     <= 1'b0;
          irq_src    <= 1'b0;
          boot_sel   <= 1'b1;
          remap      <= 1'b0;
        end
        default: begin
          fast_level <= fast_level;
        end
      endcase
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        pend <= 1'b1;
      end else if (load) begin
        pend <= 1'b0;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      if (!rd_en) begin
        rsp.read_data <= '0;
      end else if (rd_vld) begin
        rsp.read_data <= rd_q;
      end else begin
        rsp.read_data <= {31'd0, rd_boot};
      end
      rsp.fiq_out          <= fiq_en && fast_level;
      rsp.irq_out          <= irq_src && ext3_level;
      rsp.boot_rom_mapped  <= boot_sel && !remap;
      rsp.unhandled_access <= rd_unh;
    end
  end

endmodule
